// File: design/ssb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types, constants and the arctangent table for the shell cell binner.
// ----------------------------------------------------------------------------
package ssb_pkg;

    localparam int CNT_W        = 24;
    localparam int BIN_W        = 13;
    localparam int MAX_BINS     = 4096;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 36;
    localparam int SQRT_STEPS   = 32;
    localparam int ADDR_W       = 5;

    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_Z  = 3'd2;
    localparam logic [2:0] REG_OUTER     = 3'd3;
    localparam logic [2:0] REG_THICK     = 3'd4;
    localparam logic [2:0] REG_THETA_CNT = 3'd5;
    localparam logic [2:0] REG_POLAR_CNT = 3'd6;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        outer_radius;
        logic [30:0]        shell_thickness;
        logic [BIN_W-1:0]   theta_count;
        logic [BIN_W-1:0]   polar_count;
    } t_cfg;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [61:0]        sxy;
        logic               in_shell;
        logic [CNT_W-1:0]   cell_id;
        logic               start;
    } t_item;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [BIN_W-1:0] cap_bins(input logic [BIN_W-1:0] c);
        return (c > BIN_W'(MAX_BINS)) ? BIN_W'(MAX_BINS) : c;
    endfunction

endpackage
`default_nettype wire

// File: design/spherical_shell_cell_binner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spherical_shell_cell_binner_top
// Spherical shell test and azimuth/polar binning of cell centres.
// ----------------------------------------------------------------------------
// a cell outside the shell skips the root and cordic iterations; a shell cell
// passes the front states, 32 root steps, two 24-step cordic passes and the bin multiply
// the back part takes a new cell only once it has emitted the last, so its
// shared root and cordic iterations bound the rate; the front overlaps via a 2-word queue
// reset: synchronous active low, clears registers to defaults and slot counter
// ----------------------------------------------------------------------------
module spherical_shell_cell_binner_top import ssb_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [ADDR_W-1:0]  paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire [119:0]       s_axis_tdata,  // pos_x, pos_y, pos_z, cell_number
    input  wire [0:0]         s_axis_tuser,  // start_pass
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [79:0]       m_axis_tdata,  // slot_index, shell_cell, theta_bin, polar_bin
    output logic [0:0]        m_axis_tuser   // in_shell
);

    t_cfg              r_cfg;
    t_item             push_item, pop_item;
    logic              push, pop, q_full, q_valid;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic              in_shell;
    logic [CNT_W-1:0]  slot, cell_id;
    logic [BIN_W-1:0]  tbin, pbin;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x        <= '0;
            r_cfg.center_y        <= '0;
            r_cfg.center_z        <= '0;
            r_cfg.outer_radius    <= '0;
            r_cfg.shell_thickness <= '0;
            r_cfg.theta_count     <= 13'd32;
            r_cfg.polar_count     <= 13'd16;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CENTER_X:  r_cfg.center_x        <= pwdata;
                REG_CENTER_Y:  r_cfg.center_y        <= pwdata;
                REG_CENTER_Z:  r_cfg.center_z        <= pwdata;
                REG_OUTER:     r_cfg.outer_radius    <= pwdata[30:0];
                REG_THICK:     r_cfg.shell_thickness <= pwdata[30:0];
                REG_THETA_CNT: r_cfg.theta_count     <= pwdata[12:0];
                REG_POLAR_CNT: r_cfg.polar_count     <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X:  prdata = r_cfg.center_x;
            REG_CENTER_Y:  prdata = r_cfg.center_y;
            REG_CENTER_Z:  prdata = r_cfg.center_z;
            REG_OUTER:     prdata = {1'b0, r_cfg.outer_radius};
            REG_THICK:     prdata = {1'b0, r_cfg.shell_thickness};
            REG_THETA_CNT: prdata = {19'd0, r_cfg.theta_count};
            REG_POLAR_CNT: prdata = {19'd0, r_cfg.polar_count};
            default:       prdata = '0;
        endcase
    end

    ssb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pos_x (s_axis_tdata[31:0]),
        .i_pos_y (s_axis_tdata[63:32]),
        .i_pos_z (s_axis_tdata[95:64]),
        .i_cell  (s_axis_tdata[119:96]),
        .i_start (s_axis_tuser[0]),
        .o_push  (push),
        .o_item  (push_item),
        .i_full  (q_full)
    );

    ssb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (pop_item),
        .i_pop   (pop)
    );

    ssb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (q_valid),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_in_shell (in_shell),
        .o_slot     (slot),
        .o_cell     (cell_id),
        .o_theta    (tbin),
        .o_polar    (pbin)
    );

    assign m_axis_tdata = {6'd0, pbin, tbin, cell_id, slot};
    assign m_axis_tuser = in_shell;

endmodule
`default_nettype wire

// File: design/ssb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssb_front
// Accepts cell centres, forms offsets and squared distances with one shared
// multiplier, runs the shell test and pushes the classified word to the queue.
// ----------------------------------------------------------------------------
module ssb_front import ssb_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cfg             i_cfg,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [31:0]       i_pos_x,
    input  wire [31:0]       i_pos_y,
    input  wire [31:0]       i_pos_z,
    input  wire [CNT_W-1:0]  i_cell,
    input  wire              i_start,
    output logic             o_push,
    output t_item            o_item,
    input  wire              i_full
);

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_SQX  = 7'b0000010,
        F_SQY  = 7'b0000100,
        F_SQZ  = 7'b0001000,
        F_R2   = 7'b0010000,
        F_IN2  = 7'b0100000,
        F_PUSH = 7'b1000000
    } t_fstate;

    t_fstate             r_state;
    logic signed [32:0]  r_dx, r_dy, r_dz;
    logic [32:0]         r_ax, r_ay, r_az;
    logic [CNT_W-1:0]    r_cell;
    logic                r_start;
    logic [65:0]         r_acc;
    logic [61:0]         r_sxy;
    logic [61:0]         r_r2, r_i2;
    logic [32:0]         mul_a, mul_b;
    logic [65:0]         prod;
    logic signed [32:0]  n_dx, n_dy, n_dz;
    logic signed [31:0]  inner;
    logic                inner_nonpos;
    logic                shell_hit;

    assign o_ready = (r_state == F_IDLE);

    assign n_dx = $signed({i_pos_x[31], i_pos_x}) - $signed({i_cfg.center_x[31], i_cfg.center_x});
    assign n_dy = $signed({i_pos_y[31], i_pos_y}) - $signed({i_cfg.center_y[31], i_cfg.center_y});
    assign n_dz = $signed({i_pos_z[31], i_pos_z}) - $signed({i_cfg.center_z[31], i_cfg.center_z});

    assign inner = $signed({1'b0, i_cfg.outer_radius}) - $signed({1'b0, i_cfg.shell_thickness});
    assign inner_nonpos = inner[31] || (inner == 32'sd0);

    always_comb begin
        mul_a = r_ax;
        mul_b = r_ax;
        unique case (r_state)
            F_SQY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            F_SQZ: begin
                mul_a = r_az;
                mul_b = r_az;
            end
            F_R2: begin
                mul_a = {2'b00, i_cfg.outer_radius};
                mul_b = {2'b00, i_cfg.outer_radius};
            end
            F_IN2: begin
                mul_a = {2'b00, inner[30:0]};
                mul_b = {2'b00, inner[30:0]};
            end
            default: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
        endcase
    end

    assign prod = 66'(mul_a) * 66'(mul_b);

    assign shell_hit = (r_acc <= {4'b0000, r_r2}) &&
                       (inner_nonpos || (r_acc >= {4'b0000, r_i2}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_dx    <= n_dx;
                        r_dy    <= n_dy;
                        r_dz    <= n_dz;
                        r_ax    <= n_dx[32] ? 33'(-n_dx) : 33'(n_dx);
                        r_ay    <= n_dy[32] ? 33'(-n_dy) : 33'(n_dy);
                        r_az    <= n_dz[32] ? 33'(-n_dz) : 33'(n_dz);
                        r_cell  <= i_cell;
                        r_start <= i_start;
                        r_state <= F_SQX;
                    end
                end
                F_SQX: begin
                    r_acc   <= prod;
                    r_state <= F_SQY;
                end
                F_SQY: begin
                    r_acc   <= r_acc + prod;
                    r_sxy   <= 62'(r_acc + prod);
                    r_state <= F_SQZ;
                end
                F_SQZ: begin
                    r_acc   <= r_acc + prod;
                    r_state <= F_R2;
                end
                F_R2: begin
                    r_r2    <= prod[61:0];
                    r_state <= F_IN2;
                end
                F_IN2: begin
                    r_i2    <= prod[61:0];
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_item.dx       = r_dx;
        o_item.dy       = r_dy;
        o_item.dz       = r_dz;
        o_item.sxy      = r_sxy;
        o_item.in_shell = shell_hit;
        o_item.cell_id  = r_cell;
        o_item.start    = r_start;
    end

endmodule
`default_nettype wire

// File: design/ssb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssb_queue
// Two-entry queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module ssb_queue import ssb_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_item  i_item,
    output logic   o_full,
    output logic   o_valid,
    output t_item  o_item,
    input  wire    i_pop
);

    t_item        r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: design/ssb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssb_back
// Takes classified words, runs the integer root and a shared iterative CORDIC
// for azimuth and polar angle, forms the bins and assigns slot numbers.
// ----------------------------------------------------------------------------
module ssb_back import ssb_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cfg              i_cfg,
    input  wire               i_valid,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_ready,
    output logic              o_in_shell,
    output logic [CNT_W-1:0]  o_slot,
    output logic [CNT_W-1:0]  o_cell,
    output logic [BIN_W-1:0]  o_theta,
    output logic [BIN_W-1:0]  o_polar
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_SQRT = 6'b000010,
        B_CAZ  = 6'b000100,
        B_CPOL = 6'b001000,
        B_BIN  = 6'b010000,
        B_DONE = 6'b100000
    } t_bstate;

    t_bstate                    r_state;
    t_item                      r_item;
    logic [CNT_W-1:0]           r_cnt;
    logic [63:0]                r_rem, r_res, r_bit;
    logic [4:0]                 r_k;
    logic signed [CORDIC_W-1:0] r_cx, r_cy;
    logic [31:0]                r_cz;
    logic [31:0]                r_az_ang, r_pol_ang;
    logic [BIN_W-1:0]           r_tbin, r_pbin;
    logic                       r_out_valid;

    logic [63:0]                sq_try;
    logic signed [CORDIC_W-1:0] xs, ys, nx, ny;
    logic [31:0]                nz;
    logic signed [CORDIC_W-1:0] ld_a, ld_b;
    logic signed [CORDIC_W-1:0] ld_x, ld_y;
    logic [31:0]                ld_z;
    logic [44:0]                tprod;
    logic [43:0]                pprod;
    logic                       last_step;
    logic                       emit;

    assign sq_try = r_res + r_bit;

    always_comb begin
        xs = r_cx >>> r_k;
        ys = r_cy >>> r_k;
        nx = r_cx;
        ny = r_cy;
        nz = r_cz;
        if (!r_cy[CORDIC_W-1] && (r_cy != '0)) begin
            nx = r_cx + ys;
            ny = r_cy - xs;
            nz = r_cz + atan_lut(r_k);
        end else if (r_cy[CORDIC_W-1]) begin
            nx = r_cx - ys;
            ny = r_cy + xs;
            nz = r_cz - atan_lut(r_k);
        end
    end

    always_comb begin
        if (r_state == B_SQRT) begin
            ld_a = CORDIC_W'(r_item.dx);
            ld_b = CORDIC_W'(r_item.dy);
        end else begin
            ld_a = CORDIC_W'(r_item.dz);
            ld_b = $signed({{(CORDIC_W-32){1'b0}}, r_res[31:0]});
        end
        if (ld_a[CORDIC_W-1]) begin
            ld_x = -ld_a;
            ld_y = -ld_b;
            ld_z = 32'h8000_0000;
        end else begin
            ld_x = ld_a;
            ld_y = ld_b;
            ld_z = 32'h0000_0000;
        end
    end

    assign last_step = (r_k == 5'(CORDIC_STEPS - 1));
    assign tprod = 45'(r_az_ang) * 45'(cap_bins(i_cfg.theta_count));
    assign pprod = 44'(r_pol_ang) * 44'(cap_bins(i_cfg.polar_count));
    assign o_pop = (r_state == B_IDLE) && i_valid;
    assign emit  = (r_state == B_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_item;
                        if (i_item.start) begin
                            r_cnt <= '0;
                        end
                        r_rem <= {2'b00, i_item.sxy};
                        r_res <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                        r_k   <= '0;
                        r_state <= i_item.in_shell ? B_SQRT : B_DONE;
                    end
                end
                B_SQRT: begin
                    if (r_rem >= sq_try) begin
                        r_rem <= r_rem - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_k == 5'(SQRT_STEPS - 1)) begin
                        r_k  <= '0;
                        r_cx <= ld_x;
                        r_cy <= ld_y;
                        r_cz <= ld_z;
                        r_state <= B_CAZ;
                    end else begin
                        r_k <= r_k + 5'd1;
                    end
                end
                B_CAZ: begin
                    if (last_step) begin
                        r_az_ang <= nz;
                        r_k  <= '0;
                        r_cx <= ld_x;
                        r_cy <= ld_y;
                        r_cz <= ld_z;
                        r_state <= B_CPOL;
                    end else begin
                        r_cx <= nx;
                        r_cy <= ny;
                        r_cz <= nz;
                        r_k  <= r_k + 5'd1;
                    end
                end
                B_CPOL: begin
                    if (last_step) begin
                        if (nz >= 32'hC000_0000) begin
                            r_pol_ang <= '0;
                        end else if (nz > 32'h8000_0000) begin
                            r_pol_ang <= 32'h8000_0000;
                        end else begin
                            r_pol_ang <= nz;
                        end
                        r_state <= B_BIN;
                    end else begin
                        r_cx <= nx;
                        r_cy <= ny;
                        r_cz <= nz;
                        r_k  <= r_k + 5'd1;
                    end
                end
                B_BIN: begin
                    r_tbin  <= tprod[44:32];
                    r_pbin  <= pprod[43:31];
                    r_state <= B_DONE;
                end
                B_DONE: begin
                    if (emit) begin
                        o_in_shell  <= r_item.in_shell;
                        if (r_item.in_shell) begin
                            o_slot  <= r_cnt;
                            o_cell  <= r_item.cell_id;
                            o_theta <= r_tbin;
                            o_polar <= r_pbin;
                            r_cnt   <= r_cnt + CNT_W'(1);
                        end else begin
                            o_slot  <= '0;
                            o_cell  <= '0;
                            o_theta <= '0;
                            o_polar <= '0;
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// File: verif/spherical_shell_cell_binner_top_tb.sv
// ----------------------------------------------------------------------------
// spherical_shell_cell_binner_top_tb
// Self-checking bench for the shell cell binner: cell centres are streamed in
// bursts against a stalling result side, and every result word is compared
// with a bit-exact shell test, cordic angle and bin predictor kept in the tb.
// ----------------------------------------------------------------------------
module spherical_shell_cell_binner_top_tb;
    import ssb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             in_shell;
        logic [CNT_W-1:0] slot_index;
        logic [CNT_W-1:0] shell_cell;
        logic [BIN_W-1:0] theta_bin;
        logic [BIN_W-1:0] polar_bin;
    } t_bin_result;

    localparam int STALL_LIMIT = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [119:0]      s_axis_tdata = '0;  // pos_x, pos_y, pos_z, cell_number
    logic [0:0]        s_axis_tuser = '0;  // start_pass
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [79:0]       m_axis_tdata;       // slot_index, shell_cell, theta_bin, polar_bin
    logic [0:0]        m_axis_tuser;       // in_shell

    spherical_shell_cell_binner_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block's settings and slot counter
    longint            sh_cx, sh_cy, sh_cz;
    longint unsigned   sh_outer, sh_thick;
    logic [BIN_W-1:0]  sh_theta_cnt = 13'd32;
    logic [BIN_W-1:0]  sh_polar_cnt = 13'd16;
    logic [CNT_W-1:0]  slot_count = '0;

    t_bin_result expected_bins[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          stall_pct = 0;
    int          stall_phase = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] vector_angle(input longint x, input longint y);
        logic [31:0] z;
        longint      xs, ys;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut(5'(i));
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut(5'(i));
            end
        end
        return z;
    endfunction

    function automatic t_bin_result bin_cell(input logic [31:0] px, input logic [31:0] py,
                                             input logic [31:0] pz, input logic [23:0] cell_no);
        t_bin_result     r;
        longint          dx, dy, dz, inner;
        logic [65:0]     ax, ay, az, dist2, r2;
        logic [63:0]     az_ang, pol_ang, tc, pc;
        logic [127:0]    prod;
        dx = longint'($signed(px)) - sh_cx;
        dy = longint'($signed(py)) - sh_cy;
        dz = longint'($signed(pz)) - sh_cz;
        ax = 66'(dx < 0 ? -dx : dx);
        ay = 66'(dy < 0 ? -dy : dy);
        az = 66'(dz < 0 ? -dz : dz);
        dist2 = ax * ax + ay * ay + az * az;
        r2 = 66'(sh_outer) * 66'(sh_outer);
        inner = longint'(sh_outer) - longint'(sh_thick);
        r = '{1'b0, '0, '0, '0, '0};
        if (dist2 <= r2 && (inner <= 0 || dist2 >= 66'(inner) * 66'(inner))) begin
            az_ang = '0;
            pol_ang = '0;
            if (dx != 0 || dy != 0)
                az_ang = {32'd0, vector_angle(dx, dy)};
            if (dx != 0 || dy != 0 || dz != 0) begin
                pol_ang = {32'd0, vector_angle(dz,
                           longint'(int_sqrt(64'(ax * ax + ay * ay))))};
                if (pol_ang >= 64'hC000_0000) pol_ang = '0;
                else if (pol_ang > 64'h8000_0000) pol_ang = 64'h8000_0000;
            end
            tc = 64'(cap_bins(sh_theta_cnt));
            pc = 64'(cap_bins(sh_polar_cnt));
            prod = az_ang * tc;
            r.theta_bin = BIN_W'(prod >> 32);
            prod = pol_ang * pc;
            r.polar_bin = BIN_W'(prod >> 31);
            r.in_shell = 1'b1;
            r.slot_index = slot_count;
            r.shell_cell = cell_no;
            slot_count = slot_count + 1'b1;
        end
        return r;
    endfunction

    // result stall pattern changes in phases of the stall_phase counter
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 300 == 0) stall_pct <= $urandom_range(0, 3) * 25;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_bin_result exp_r, got;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.in_shell   = m_axis_tuser[0];
                got.slot_index = m_axis_tdata[23:0];
                got.shell_cell = m_axis_tdata[47:24];
                got.theta_bin  = m_axis_tdata[60:48];
                got.polar_bin  = m_axis_tdata[73:61];
                if (expected_bins.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %p", got);
                end else begin
                    exp_r = expected_bins.pop_front();
                    if (got !== exp_r || m_axis_tdata[79:74] !== 6'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", exp_r, got);
                    end
                end
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CENTER_X:  sh_cx = longint'($signed(val));
            REG_CENTER_Y:  sh_cy = longint'($signed(val));
            REG_CENTER_Z:  sh_cz = longint'($signed(val));
            REG_OUTER:     sh_outer = 64'(val[30:0]);
            REG_THICK:     sh_thick = 64'(val[30:0]);
            REG_THETA_CNT: sh_theta_cnt = val[12:0];
            REG_POLAR_CNT: sh_polar_cnt = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [31:0] outer,
                             input logic [31:0] thick, input logic [12:0] tcnt,
                             input logic [12:0] pcnt);
        drain();
        cfg_write(REG_CENTER_X, cx);
        cfg_write(REG_CENTER_Y, cy);
        cfg_write(REG_CENTER_Z, cz);
        cfg_write(REG_OUTER, outer);
        cfg_write(REG_THICK, thick);
        cfg_write(REG_THETA_CNT, {19'd0, tcnt});
        cfg_write(REG_POLAR_CNT, {19'd0, pcnt});
    endtask

    task automatic send_cell(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [23:0] cell_no,
                             input logic start);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cell_no, pz, py, px};
        s_axis_tuser <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (start) slot_count = '0;
        expected_bins.push_back(bin_cell(px, py, pz, cell_no));
        burst_left--;
    endtask

    task automatic end_stream;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic [31:0] q16(input int v);
        return 32'(v) << 16;
    endfunction

    task automatic test_directed;
        configure('0, '0, '0, q16(10), q16(10), 13'd32, 13'd16);
        send_cell('0, '0, '0, 24'd0, 1'b1);
        send_cell('0, '0, q16(5), 24'hFFFFFF, 1'b0);
        send_cell('0, '0, q16(-5), 24'd1, 1'b0);
        send_cell(q16(5), '0, '0, 24'd2, 1'b0);
        send_cell(q16(-5), '0, '0, 24'd3, 1'b0);
        send_cell('0, q16(5), '0, 24'd4, 1'b0);
        send_cell('0, q16(-5), '0, 24'd5, 1'b0);
        send_cell(q16(3), q16(4), '0, 24'd6, 1'b0);
        send_cell(q16(-3), q16(-4), q16(2), 24'd7, 1'b0);
        send_cell(q16(20), '0, '0, 24'd8, 1'b0);
        send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'd9, 1'b0);
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd10, 1'b0);
        end_stream();
        // thin shell: inner radius 8
        configure('0, '0, '0, q16(10), q16(2), 13'd1, 13'd2);
        send_cell(q16(5), '0, '0, 24'd11, 1'b1);
        send_cell(q16(8), '0, '0, 24'd12, 1'b0);
        send_cell('0, q16(9), '0, 24'd13, 1'b0);
        send_cell('0, '0, q16(10), 24'd14, 1'b0);
        send_cell('0, '0, q16(10) + 32'd1, 24'd15, 1'b0);
        send_cell(q16(6), q16(-8), '0, 24'd16, 1'b1);
        send_cell(q16(-6), q16(8), q16(-1), 24'd17, 1'b0);
        end_stream();
    endtask

    task automatic test_shell_sweep(input int n, input longint span);
        logic [31:0] p[3];
        longint      c[3];
        c[0] = sh_cx;
        c[1] = sh_cy;
        c[2] = sh_cz;
        for (int k = 0; k < n; k++) begin
            for (int a = 0; a < 3; a++) begin
                if ($urandom_range(0, 9) < 8)
                    p[a] = 32'(c[a] + longint'({$urandom, $urandom} % (2 * span + 1)) - span);
                else
                    p[a] = $urandom;
            end
            send_cell(p[0], p[1], p[2], 24'($urandom), ($urandom_range(0, 49) == 0));
        end
        end_stream();
    endtask

    task automatic test_random_phases;
        longint rad;
        configure($urandom, $urandom, $urandom, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  13'd4096, 13'd4096);
        test_shell_sweep(260, 64'h7FFF_FFFF);
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                  13'd8191, 13'd8191);
        test_shell_sweep(200, 64'h7FFF_FFFF);
        configure('0, '0, '0, 32'h7FFF_FFFF, 32'h2000_0000, 13'd0, 13'd0);
        test_shell_sweep(200, 64'h7FFF_FFFF);
        for (int ph = 0; ph < 4; ph++) begin
            rad = $urandom_range(1, 32'h3FFF_FFFF);
            configure($urandom, $urandom, $urandom, 32'(rad),
                      32'($urandom_range(1, 32'(rad))),
                      13'($urandom_range(1, 8191)), 13'($urandom_range(2, 8191)));
            test_shell_sweep(230, rad);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        drain();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
